// ----- rtl/psu_pkg.sv -----
// Shared types, register indexes and ROM builder functions for the Phong shading unit.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package psu_pkg;

    localparam int unsigned POW_TABLE_ADDR_BITS_DEF = 8;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_DIFFUSE_RED    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIFFUSE_GREEN  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIFFUSE_BLUE   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPECULAR_RED   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPECULAR_GREEN = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPECULAR_BLUE  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHININESS      = 3'd6;

    localparam logic [15:0] COLOR_RESET     = 16'hFFFF;
    localparam logic [15:0] SHININESS_RESET = 16'h0100;
    localparam logic [16:0] FACTOR_ONE      = 17'h10000;

    typedef struct packed {
        logic signed [15:0] view_x;
        logic signed [15:0] view_y;
        logic signed [15:0] view_z;
        logic signed [15:0] light_x;
        logic signed [15:0] light_y;
        logic signed [15:0] light_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
    } psu_in_t;

    typedef struct packed {
        logic [16:0] out_red;
        logic [16:0] out_green;
        logic [16:0] out_blue;
    } psu_out_t;

    // diffuse and specular base factors, Q1.16 saturated to 1.0
    typedef struct packed {
        logic [16:0] fd;
        logic [16:0] b;
    } psu_fac_t;

    typedef struct packed {
        logic [15:0] diff_r;
        logic [15:0] diff_g;
        logic [15:0] diff_b;
        logic [15:0] spec_r;
        logic [15:0] spec_g;
        logic [15:0] spec_b;
    } psu_color_cfg_t;

    // 24-bit fractional log2 of x in Q1.30 by repeated squaring
    function automatic logic [23:0] psu_log2_frac24(logic [63:0] x_in);
        logic [63:0] x;
        logic [23:0] r;
        x = x_in;
        r = '0;
        for (int k = 0; k < 24; k++) begin
            x = (x * x) >> 30;
            r = {r[22:0], 1'b0};
            if (x >= 64'h8000_0000) begin
                r[0] = 1'b1;
                x = x >> 1;
            end
        end
        return r;
    endfunction

    function automatic logic [15:0] psu_log_rom(int unsigned idx, int unsigned abits);
        logic [63:0] x;
        logic [23:0] lg;
        x = (64'd1 << 30) + (64'(idx) << (30 - abits));
        lg = psu_log2_frac24(x);
        return lg[23:8];
    endfunction

    // smallest mantissa whose log2 reaches the table point
    function automatic logic [16:0] psu_exp_rom(int unsigned idx, int unsigned abits);
        logic [63:0] target;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        if (idx == 0) begin
            return FACTOR_ONE;
        end
        target = 64'((64'd1 << abits) - 64'(idx)) << (24 - abits);
        lo = 32768;
        hi = 65536;
        while (lo < hi) begin
            mid = (lo + hi) >> 1;
            if (64'(psu_log2_frac24(64'(mid) << 15)) >= target) begin
                hi = mid;
            end else begin
                lo = mid + 1;
            end
        end
        return 17'(lo);
    endfunction

endpackage

// ----- rtl/psu_geom.sv -----
// Geometry pipeline: L.N, reflected vector R and V.R, six stages.
// Produces the diffuse factor and the specular base; depends on psu_pkg.
`timescale 1ns / 1ps

module psu_geom import psu_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     en,
    input  logic     in_valid,
    input  psu_in_t  in_data,
    output logic     out_valid,
    output psu_fac_t out_fac
);

    logic signed [15:0] v_in [3];
    logic signed [15:0] l_in [3];
    logic signed [15:0] n_in [3];

    assign v_in[0] = in_data.view_x;
    assign v_in[1] = in_data.view_y;
    assign v_in[2] = in_data.view_z;
    assign l_in[0] = in_data.light_x;
    assign l_in[1] = in_data.light_y;
    assign l_in[2] = in_data.light_z;
    assign n_in[0] = in_data.norm_x;
    assign n_in[1] = in_data.norm_y;
    assign n_in[2] = in_data.norm_z;

    logic [5:0] vld_reg;

    // stage 1
    logic signed [31:0] ln1_reg [3];
    logic signed [15:0] v1_reg [3];
    logic signed [15:0] l1_reg [3];
    logic signed [15:0] n1_reg [3];
    // stage 2
    logic signed [33:0] d2_reg;
    logic signed [15:0] v2_reg [3];
    logic signed [15:0] l2_reg [3];
    logic signed [15:0] n2_reg [3];
    // stage 3
    logic signed [49:0] dn3_reg [3];
    logic signed [15:0] v3_reg [3];
    logic signed [15:0] l3_reg [3];
    logic [16:0]        fd3_reg;
    // stage 4
    logic signed [37:0] r4_reg [3];
    logic signed [15:0] v4_reg [3];
    logic [16:0]        fd4_reg;
    // stage 5
    logic signed [53:0] vr5_reg [3];
    logic [16:0]        fd5_reg;
    // stage 6
    psu_fac_t           fac6_reg;

    logic signed [33:0] d_next;
    logic [16:0]        fd_next;
    logic signed [51:0] rf_next [3];
    logic signed [55:0] s_next;
    logic [16:0]        b_next;

    always_comb begin
        d_next = 34'(ln1_reg[0]) + 34'(ln1_reg[1]) + 34'(ln1_reg[2]);

        if (d2_reg <= 0) begin
            fd_next = '0;
        end else if (|d2_reg[32:28]) begin
            fd_next = FACTOR_ONE;
        end else begin
            fd_next = {1'b0, d2_reg[27:12]};
        end

        // arithmetic shift gives the floor toward minus infinity
        for (int k = 0; k < 3; k++) begin
            rf_next[k] = ((52'(l3_reg[k]) <<< 28) - (52'(dn3_reg[k]) <<< 1)) >>> 14;
        end

        s_next = 56'(vr5_reg[0]) + 56'(vr5_reg[1]) + 56'(vr5_reg[2]);
    end

    always_comb begin
        if (s_next <= 0) begin
            b_next = '0;
        end else if (|s_next[54:42]) begin
            b_next = FACTOR_ONE;
        end else begin
            b_next = {1'b0, s_next[41:26]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                ln1_reg[k] <= l_in[k] * n_in[k];
                v1_reg[k]  <= v_in[k];
                l1_reg[k]  <= l_in[k];
                n1_reg[k]  <= n_in[k];

                v2_reg[k]  <= v1_reg[k];
                l2_reg[k]  <= l1_reg[k];
                n2_reg[k]  <= n1_reg[k];

                dn3_reg[k] <= 50'(d2_reg) * 50'(n2_reg[k]);
                v3_reg[k]  <= v2_reg[k];
                l3_reg[k]  <= l2_reg[k];

                r4_reg[k]  <= rf_next[k][37:0];
                v4_reg[k]  <= v3_reg[k];

                vr5_reg[k] <= 54'(v4_reg[k]) * 54'(r4_reg[k]);
            end
            d2_reg      <= d_next;
            fd3_reg     <= fd_next;
            fd4_reg     <= fd3_reg;
            fd5_reg     <= fd4_reg;
            fac6_reg.fd <= fd5_reg;
            fac6_reg.b  <= b_next;
        end
    end

    assign out_valid = vld_reg[5];
    assign out_fac   = fac6_reg;

endmodule

// ----- rtl/psu_pow.sv -----
// Power unit: specular base raised to the shininess via log2/exp2 ROMs, four stages.
// ROM contents are built at elaboration by psu_pkg functions.
`timescale 1ns / 1ps

module psu_pow import psu_pkg::*; #(
    parameter int unsigned POW_TABLE_ADDR_BITS = POW_TABLE_ADDR_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  psu_fac_t    in_fac,
    input  logic [15:0] shininess,
    output logic        out_valid,
    output logic [16:0] out_fd,
    output logic [16:0] out_fs
);

    localparam int unsigned A    = POW_TABLE_ADDR_BITS;
    localparam int unsigned TBL  = 1 << A;
    localparam int unsigned ZLSB = 24 - A;

    logic [15:0] log_tbl [TBL];
    logic [16:0] exp_tbl [TBL];

    for (genvar g = 0; g < TBL; g++) begin : g_rom
        assign log_tbl[g] = psu_log_rom(g, A);
        assign exp_tbl[g] = psu_exp_rom(g, A);
    end

    logic [3:0] vld_reg;

    logic [3:0]   p1_reg;
    logic [A-1:0] i1_reg;
    logic         one1_reg, zero1_reg;
    logic [16:0]  fd1_reg;

    logic [20:0]  t2_reg;
    logic         one2_reg, zero2_reg;
    logic [16:0]  fd2_reg;

    logic [4:0]   q3_reg;
    logic         big3_reg;
    logic [A-1:0] j3_reg;
    logic         one3_reg, zero3_reg;
    logic [16:0]  fd3_reg;

    logic [16:0]  fs4_reg;
    logic [16:0]  fd4_reg;

    logic [3:0]   p_next;
    logic [15:0]  norm_next;
    logic [20:0]  t_next;
    logic [36:0]  prod_next;
    logic [16:0]  fs_next;

    always_comb begin
        // msb position; the top bit is handled by the saturate flag
        p_next = '0;
        for (int k = 0; k < 16; k++) begin
            if (in_fac.b[k]) begin
                p_next = 4'(k);
            end
        end
        norm_next = in_fac.b[15:0] << (4'd15 - p_next);

        t_next = (21'(5'd16 - {1'b0, p1_reg}) << 16) - 21'(log_tbl[i1_reg]);

        prod_next = 37'(t2_reg) * 37'(shininess);

        if (one3_reg) begin
            fs_next = FACTOR_ONE;
        end else if (zero3_reg || big3_reg) begin
            fs_next = '0;
        end else begin
            fs_next = exp_tbl[j3_reg] >> q3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg    <= p_next;
            i1_reg    <= norm_next[14 -: A];
            one1_reg  <= (shininess == '0) || in_fac.b[16];
            zero1_reg <= (in_fac.b == '0);
            fd1_reg   <= in_fac.fd;

            t2_reg    <= t_next;
            one2_reg  <= one1_reg;
            zero2_reg <= zero1_reg;
            fd2_reg   <= fd1_reg;

            q3_reg    <= prod_next[28:24];
            big3_reg  <= (|prod_next[36:29]) || (prod_next[28:24] > 5'd16);
            j3_reg    <= prod_next[ZLSB +: A];
            one3_reg  <= one2_reg;
            zero3_reg <= zero2_reg;
            fd3_reg   <= fd2_reg;

            fs4_reg   <= fs_next;
            fd4_reg   <= fd3_reg;
        end
    end

    assign out_valid = vld_reg[3];
    assign out_fd    = fd4_reg;
    assign out_fs    = fs4_reg;

    a_fs_bounded : assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[3] |-> (fs4_reg <= FACTOR_ONE))
        else $error("specular factor above one");

    a_fd_bounded : assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[3] |-> (fd4_reg <= FACTOR_ONE))
        else $error("diffuse factor above one");

    a_stall_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg) && $stable(fs4_reg))
        else $error("power pipeline moved during stall");

endmodule

// ----- rtl/psu_color.sv -----
// Color stage: weights the material colors by the two factors, two stages.
// The second stage is the output register; depends on psu_pkg.
`timescale 1ns / 1ps

module psu_color import psu_pkg::*; (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  logic [16:0]    in_fd,
    input  logic [16:0]    in_fs,
    input  psu_color_cfg_t cfg,
    output logic           out_valid,
    output psu_out_t       out_data
);

    logic [15:0] cd [3];
    logic [15:0] cs [3];

    assign cd[0] = cfg.diff_r;
    assign cd[1] = cfg.diff_g;
    assign cd[2] = cfg.diff_b;
    assign cs[0] = cfg.spec_r;
    assign cs[1] = cfg.spec_g;
    assign cs[2] = cfg.spec_b;

    logic [1:0]  vld_reg;
    logic [32:0] pd1_reg [3];
    logic [32:0] ps1_reg [3];
    logic [16:0] ch2_reg [3];
    logic [33:0] acc_next [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            acc_next[k] = 34'(pd1_reg[k]) + 34'(ps1_reg[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                pd1_reg[k] <= 33'(cd[k]) * 33'(in_fd);
                ps1_reg[k] <= 33'(cs[k]) * 33'(in_fs);
                ch2_reg[k] <= acc_next[k][32:16];
            end
        end
    end

    assign out_valid          = vld_reg[1];
    assign out_data.out_red   = ch2_reg[0];
    assign out_data.out_green = ch2_reg[1];
    assign out_data.out_blue  = ch2_reg[2];

endmodule

// ----- rtl/phong_shading_unit.sv -----
// Pipeline stages from input transaction to result: 6 geometry, 4 power, 2 color.
// Throughput: one transaction per cycle; the whole pipeline advances together and
// holds while a result waits at the output register.
// Reset: synchronous active-low aresetn clears all valid bits and loads the
// register defaults (colors 0xFFFF, shininess 1.0).
`timescale 1ns / 1ps

module phong_shading_unit import psu_pkg::*; #(
    parameter int unsigned POW_TABLE_ADDR_BITS = POW_TABLE_ADDR_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  psu_in_t                s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output psu_out_t               m_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    psu_color_cfg_t color_reg;
    logic [15:0]    shin_reg;

    logic     en;
    logic     geo_valid, pow_valid;
    psu_fac_t geo_fac;
    logic [16:0] pow_fd, pow_fs;

    // advance everything unless the output holds an untaken result
    assign en        = !m_valid || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_reg <= '{COLOR_RESET, COLOR_RESET, COLOR_RESET,
                           COLOR_RESET, COLOR_RESET, COLOR_RESET};
            shin_reg  <= SHININESS_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_DIFFUSE_RED:    color_reg.diff_r <= cfg_data;
                CFG_DIFFUSE_GREEN:  color_reg.diff_g <= cfg_data;
                CFG_DIFFUSE_BLUE:   color_reg.diff_b <= cfg_data;
                CFG_SPECULAR_RED:   color_reg.spec_r <= cfg_data;
                CFG_SPECULAR_GREEN: color_reg.spec_g <= cfg_data;
                CFG_SPECULAR_BLUE:  color_reg.spec_b <= cfg_data;
                CFG_SHININESS:      shin_reg         <= cfg_data;
                default: ;
            endcase
        end
    end

    psu_geom u_geom (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .out_valid (geo_valid),
        .out_fac   (geo_fac)
    );

    psu_pow #(
        .POW_TABLE_ADDR_BITS (POW_TABLE_ADDR_BITS)
    ) u_pow (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (geo_valid),
        .in_fac    (geo_fac),
        .shininess (shin_reg),
        .out_valid (pow_valid),
        .out_fd    (pow_fd),
        .out_fs    (pow_fs)
    );

    psu_color u_color (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (pow_valid),
        .in_fd     (pow_fd),
        .in_fs     (pow_fs),
        .cfg       (color_reg),
        .out_valid (m_valid),
        .out_data  (m_data)
    );

    a_red_range : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.out_red <= 17'd131070))
        else $error("red out of range");

    a_green_range : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.out_green <= 17'd131070))
        else $error("green out of range");

    a_blue_range : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.out_blue <= 17'd131070))
        else $error("blue out of range");

    a_reset_empty : assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for phong_shading_unit: drives shading points and
// register writes, predicts colors with its own fixed-point Phong model.
// Depends on psu_pkg and the phong_shading_unit RTL.
`timescale 1ns / 1ps

class shade_scoreboard;
    logic [15:0] color_reg[6];
    logic [15:0] shine;
    psu_pkg::psu_out_t pending_colors[$];
    int errors;
    logic [15:0] log_tab[256];
    logic [16:0] exp_tab[256];

    function new();
        for (int k = 0; k < 6; k++) color_reg[k] = psu_pkg::COLOR_RESET;
        shine = psu_pkg::SHININESS_RESET;
        errors = 0;
        build_tables();
    endfunction

    // 24-bit fractional log2 of a Q1.30 mantissa, truncated squaring
    function automatic longint unsigned frac_log2(longint unsigned x);
        longint unsigned r;
        r = 0;
        for (int k = 0; k < 24; k++) begin
            x = (x * x) >> 30;
            r = r << 1;
            if (x >= 64'h8000_0000) begin
                r = r | 1;
                x = x >> 1;
            end
        end
        return r;
    endfunction

    function void build_tables();
        longint unsigned goal;
        int unsigned lo, hi, mid;
        for (int i = 0; i < 256; i++) begin
            log_tab[i] = 16'(frac_log2((64'd1 << 30) + (64'(i) << 22)) >> 8);
            if (i == 0) begin
                exp_tab[i] = psu_pkg::FACTOR_ONE;
            end else begin
                goal = 64'(256 - i) << 16;
                lo = 32768;
                hi = 65536;
                while (lo < hi) begin
                    mid = (lo + hi) / 2;
                    if (frac_log2(64'(mid) << 15) >= goal) hi = mid;
                    else lo = mid + 1;
                end
                exp_tab[i] = 17'(lo);
            end
        end
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] val);
        if (idx == psu_pkg::CFG_SHININESS) shine = val;
        else if (idx < psu_pkg::CFG_SHININESS) color_reg[idx] = val;
    endfunction

    function longint floor_div14(longint x);
        return x >>> 14;
    endfunction

    function longint unsigned spec_power(longint unsigned b);
        int unsigned p, i, q, j;
        longint unsigned t, z;
        if (shine == 0) return 65536;
        if (b == 0) return 0;
        if (b >= 65536) return 65536;
        p = 0;
        while (p < 15 && (b >> (p + 1)) != 0) p++;
        i = ((b << (15 - p)) >> 7) & 8'hFF;
        t = 64'(16 - p) * 65536 - log_tab[i];
        z = (t * shine) >> 16;
        q = z >> 8;
        j = z & 8'hFF;
        if (q > 16) return 0;
        return exp_tab[j] >> q;
    endfunction

    function void note_point(psu_pkg::psu_in_t it);
        longint v[3], l[3], n[3], r[3], d, s;
        longint unsigned fd, fs, b, acc[3];
        psu_pkg::psu_out_t res;
        v = '{it.view_x, it.view_y, it.view_z};
        l = '{it.light_x, it.light_y, it.light_z};
        n = '{it.norm_x, it.norm_y, it.norm_z};
        d = l[0] * n[0] + l[1] * n[1] + l[2] * n[2];
        fd = (d <= 0) ? 0 : (((d >>> 12) >= 65536) ? 65536 : longint'(d >>> 12));
        for (int k = 0; k < 3; k++) r[k] = floor_div14(l[k] * 268435456 - 2 * d * n[k]);
        s = v[0] * r[0] + v[1] * r[1] + v[2] * r[2];
        b = (s <= 0) ? 0 : (((s >>> 26) >= 65536) ? 65536 : longint'(s >>> 26));
        fs = spec_power(b);
        for (int k = 0; k < 3; k++) acc[k] = (color_reg[k] * fd + color_reg[k+3] * fs) >> 16;
        res.out_red = 17'(acc[0]);
        res.out_green = 17'(acc[1]);
        res.out_blue = 17'(acc[2]);
        pending_colors.push_back(res);
    endfunction

    function void check_color(psu_pkg::psu_out_t got);
        psu_pkg::psu_out_t want;
        if (pending_colors.size() == 0) begin
            $display("%0t: unexpected color %h", $time, got);
            errors++;
            return;
        end
        want = pending_colors.pop_front();
        if (got.out_red !== want.out_red)
            $display("%0t: red expected %0d actual %0d", $time, want.out_red, got.out_red);
        if (got.out_green !== want.out_green)
            $display("%0t: green expected %0d actual %0d", $time, want.out_green, got.out_green);
        if (got.out_blue !== want.out_blue)
            $display("%0t: blue expected %0d actual %0d", $time, want.out_blue, got.out_blue);
        if (got !== want) errors++;
    endfunction
endclass

module testbench;
    import psu_pkg::*;

    logic aclk = 0, aresetn = 0;
    logic s_valid = 0, s_ready, m_valid, m_ready = 0;
    psu_in_t s_data = '0;
    psu_out_t m_data;
    logic cfg_valid = 0, cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int send_idle = 0, recv_stall = 0;
    longint cycle_count = 0;
    shade_scoreboard colors_sb;

    phong_shading_unit u_top (.*);

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > 400000) begin
            $display("FAIL phong_shading_unit");
            $finish;
        end
        if (aresetn && m_valid && m_ready) colors_sb.check_color(m_data);
    end

    // receiver side: stall at the configured rate
    always @(negedge aclk) m_ready <= ($urandom_range(99) >= recv_stall);

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1;
        do @(posedge aclk); while (!cfg_ready);
        colors_sb.write_reg(idx, val);
        @(negedge aclk);
        cfg_valid <= 0;
        @(negedge aclk);
    endtask

    task automatic send_point(psu_in_t it);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 0;
            @(negedge aclk);
        end
        s_data <= it;
        s_valid <= 1;
        do @(posedge aclk); while (!s_ready);
        colors_sb.note_point(it);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 0;
        while (colors_sb.pending_colors.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    function automatic logic [15:0] unit_comp();
        case ($urandom_range(5))
            0: return 16'sh4000;
            1: return 16'shC000;
            2: return 16'h0000;
            default: return 16'($signed($urandom_range(32768)) - 16384);
        endcase
    endfunction

    function automatic psu_in_t random_point();
        psu_in_t it;
        if ($urandom_range(9) < 2) begin
            it = 144'({$urandom, $urandom, $urandom, $urandom, $urandom});
        end else begin
            it = {unit_comp(), unit_comp(), unit_comp(), unit_comp(), unit_comp(),
                  unit_comp(), unit_comp(), unit_comp(), unit_comp()};
            // half the time, use an exact unit normal along +z or -z for a realistic spread
            if ($urandom_range(1)) begin
                it.norm_x = '0;
                it.norm_y = '0;
                it.norm_z = $urandom_range(1) ? 16'sh4000 : 16'shC000;
            end
        end
        return it;
    endfunction

    task automatic random_phase(int count, int idle, int stall);
        send_idle = idle;
        recv_stall = stall;
        for (int k = 0; k < count; k++) send_point(random_point());
        drain();
    endtask

    initial begin
        psu_in_t it;
        colors_sb = new();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // directed: extremes and the special cases
        send_point('0);
        send_point({9{16'h7FFF}});
        send_point({9{16'h8000}});
        it = '0;
        it.light_z = 16'sh4000; it.norm_z = 16'sh4000; it.view_z = 16'shC000;
        send_point(it);
        it.view_z = 16'sh4000;
        send_point(it);
        it.view_x = 16'shD2BF; it.view_z = 16'shD2BF; it.light_x = 16'sh2D41;
        send_point(it);
        it.light_z = 16'shC000;
        send_point(it);
        send_point({16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                    16'h7FFF, 16'h8000, 16'h7FFF});
        drain();
        write_reg(CFG_SHININESS, 16'h0000);
        send_point(it);
        send_point('0);
        drain();

        write_reg(CFG_DIFFUSE_RED, 16'h0000);
        write_reg(CFG_DIFFUSE_GREEN, 16'h8000);
        write_reg(CFG_DIFFUSE_BLUE, 16'hFFFF);
        write_reg(CFG_SPECULAR_RED, 16'hFFFF);
        write_reg(CFG_SPECULAR_GREEN, 16'h0000);
        write_reg(CFG_SPECULAR_BLUE, 16'h1234);
        write_reg(CFG_SHININESS, 16'hFFFF);
        random_phase(250, 0, 0);
        write_reg(CFG_SHININESS, 16'h2000);
        random_phase(250, 75, 0);
        for (int r = 0; r < 7; r++) write_reg(3'(r), 16'($urandom));
        write_reg(CFG_SHININESS, 16'h0080);
        random_phase(250, 0, 75);
        write_reg(CFG_SHININESS, 16'h0001);
        random_phase(250, 14, 14);
        for (int r = 0; r < 6; r++) write_reg(3'(r), 16'hFFFF);
        write_reg(CFG_SHININESS, 16'($urandom));
        random_phase(390, $urandom_range(1) ? 0 : 14, 0);

        if (colors_sb.errors == 0 && colors_sb.pending_colors.size() == 0) begin
            $display("PASS phong_shading_unit");
        end else begin
            $display("FAIL phong_shading_unit");
        end
        $finish;
    end
endmodule
